// ===== rtl/nmeachk_pkg.sv =====
// Shared types, character codes and helpers for the NMEA 0183 sentence checker.
package nmeachk_pkg;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_CANNOT_PARSE = 2'd1,
    ST_BAD_SUM      = 2'd2
  } status_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LOW    = 8'h20;
  localparam logic [7:0] CH_HIGH   = 8'h7E;

  // index of the last identifier character (marker sits at index 0)
  localparam int unsigned ID_LAST   = 5;
  // shortest sentence that yields a result
  localparam int unsigned MIN_LEN   = 6;
  // a '*' this close to the end means a checksum field is present
  localparam int unsigned SUM_TAIL  = 6;
  localparam int unsigned SUM_CHARS = 2;
  // reported length field; a wider saturated count keeps its low bits
  localparam int unsigned LEN_OUT_W = 11;

  typedef struct packed {
    logic        fire;
    status_t     status;
    logic [39:0] id;
    logic [7:0]  sum;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== rtl/nmeachk_parser.sv =====
// Per-byte sentence state and result evaluation.
module nmeachk_parser import nmeachk_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024,
  parameter int unsigned LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  logic             last_byte,
  output result_t          res,
  output logic [LEN_W-1:0] res_len
);

  logic             in_sentence, in_sentence_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       xor_acc, xor_acc_next;
  logic             star_seen, star_seen_next;
  logic [LEN_W-1:0] last_star, last_star_next;
  logic [15:0]      sum_chars, sum_chars_next;
  logic [1:0]       sum_cnt, sum_cnt_next;
  logic             garbage, garbage_next;
  logic [39:0]      id_chars, id_chars_next;

  logic             bad_char;
  logic [4:0]       hex_hi, hex_lo;
  logic             sum_match, has_sum;

  assign bad_char = (byte_in < CH_LOW || byte_in > CH_HIGH) &&
                    byte_in != CH_CR && byte_in != CH_LF;

  always_comb begin
    in_sentence_next = in_sentence;
    len_next         = len;
    xor_acc_next     = xor_acc;
    star_seen_next   = star_seen;
    last_star_next   = last_star;
    sum_chars_next   = sum_chars;
    sum_cnt_next     = sum_cnt;
    garbage_next     = garbage;
    id_chars_next    = id_chars;
    if (!in_sentence) begin
      // idle state is always cleared, so only the marker matters
      if (byte_in == CH_DOLLAR || byte_in == CH_BANG) begin
        in_sentence_next = 1'b1;
        len_next         = LEN_W'(1);
      end
    end else begin
      if (len < LEN_W'(MAX_LEN)) len_next = len + LEN_W'(1);
      if (bad_char) garbage_next = 1'b1;
      if (len <= LEN_W'(ID_LAST)) id_chars_next = {id_chars[31:0], byte_in};
      if (star_seen && sum_cnt < 2'(SUM_CHARS)) begin
        sum_chars_next = {sum_chars[7:0], byte_in};
        sum_cnt_next   = sum_cnt + 2'd1;
      end
      if (byte_in == CH_STAR) begin
        star_seen_next = 1'b1;
        last_star_next = len;
      end else if (!star_seen) begin
        xor_acc_next = xor_acc ^ byte_in;
      end
    end
  end

  // result is judged on the state after this byte
  assign hex_hi    = hex_decode(sum_chars_next[15:8]);
  assign hex_lo    = hex_decode(sum_chars_next[7:0]);
  assign sum_match = sum_cnt_next == 2'(SUM_CHARS) && hex_hi[4] && hex_lo[4] &&
                     {hex_hi[3:0], hex_lo[3:0]} == xor_acc_next;
  assign has_sum   = star_seen_next &&
                     ({1'b0, last_star_next} + (LEN_W+1)'(SUM_TAIL) >= {1'b0, len_next});

  always_comb begin
    res.fire   = last_byte && in_sentence_next && len_next >= LEN_W'(MIN_LEN);
    res.sum    = xor_acc_next;
    res.id     = id_chars_next;
    res.status = ST_OK;
    if (garbage_next) begin
      res.status = ST_CANNOT_PARSE;
      res.id     = 40'd0;
    end else if (has_sum && !sum_match) begin
      res.status = ST_BAD_SUM;
    end
  end

  assign res_len = len_next;

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      in_sentence <= 1'b0;
      len         <= '0;
      xor_acc     <= '0;
      star_seen   <= 1'b0;
      last_star   <= '0;
      sum_chars   <= '0;
      sum_cnt     <= '0;
      garbage     <= 1'b0;
      id_chars    <= '0;
    end else if (step) begin
      in_sentence <= in_sentence_next;
      len         <= len_next;
      xor_acc     <= xor_acc_next;
      star_seen   <= star_seen_next;
      last_star   <= last_star_next;
      sum_chars   <= sum_chars_next;
      sum_cnt     <= sum_cnt_next;
      garbage     <= garbage_next;
      id_chars    <= id_chars_next;
    end
  end

endmodule

// ===== rtl/nmea0183_sentence_checker.sv =====
// Top level: input register, sentence parser and result register.
// out_valid is registered: the last byte passes the input register and the parser, then sets the result register.
// Throughput: one byte per cycle while no result is stalled downstream; the parser state updates in a single pass.
// A result stalled downstream holds back only a byte that would give another result.
// Reset (rst, synchronous) clears the sentence state and both valid flags.
module nmea0183_sentence_checker import nmeachk_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [39:0]          sentence_id,
  output logic [LEN_OUT_W-1:0] sentence_length,
  output logic [7:0]           computed_sum
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  logic             q_valid;
  logic [7:0]       q_byte;
  logic             q_last;
  logic             advance;
  result_t          res;
  logic [LEN_W-1:0] res_len;

  nmeachk_parser #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (q_byte),
    .last_byte (q_last),
    .res       (res),
    .res_len   (res_len)
  );

  // bytes that produce no result never wait on the output side
  assign advance  = q_valid && (!res.fire || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_byte <= byte_in;
      q_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      status          <= res.status;
      sentence_id     <= res.id;
      sentence_length <= LEN_OUT_W'(res_len);
      computed_sum    <= res.sum;
    end
  end

endmodule

// ===== rtl/nmeachk_checker.sv =====
// Port-level assertions for the sentence checker, bound to the top level.
module nmeachk_checker import nmeachk_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [1:0]           status,
  input logic [39:0]          sentence_id,
  input logic [LEN_OUT_W-1:0] sentence_length
);

  // range check only means something when the saturated length fits the port
  localparam bit LEN_FITS = MAX_LEN < (1 << LEN_OUT_W);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(sentence_id) && $stable(sentence_length))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_CANNOT_PARSE || status == ST_BAD_SUM)
    else $error("undefined status code");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && LEN_FITS |-> sentence_length >= LEN_OUT_W'(MIN_LEN) &&
      sentence_length <= LEN_OUT_W'(MAX_LEN))
    else $error("sentence length out of range");

  a_garbage_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_CANNOT_PARSE |-> sentence_id == 40'd0)
    else $error("identifier not cleared on unparsable sentence");

endmodule

bind nmea0183_sentence_checker nmeachk_checker #(.MAX_LEN(MAX_LEN)) u_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .sentence_id     (sentence_id),
  .sentence_length (sentence_length)
);

// ===== verif/nmea0183_sentence_checker_test.sv =====
// Self-checking testbench for the NMEA 0183 sentence checker: directed and random lines.
`timescale 1ns / 1ps
module nmea0183_sentence_checker_test;
  import nmeachk_pkg::*;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    status_t              status;
    logic [39:0]          id;
    logic [LEN_OUT_W-1:0] len;
    logic [7:0]           sum;
  } sentence_result_t;

  typedef enum int {
    SUM_INTACT,
    SUM_WRONG,
    SUM_NOT_HEX,
    SUM_SHORT
  } sum_damage_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           byte_in = 8'h00;
  logic                 last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           status;
  logic [39:0]          sentence_id;
  logic [LEN_OUT_W-1:0] sentence_length;
  logic [7:0]           computed_sum;

  nmea0183_sentence_checker #(.MAX_LEN(MAX_LEN)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .byte_in(byte_in),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .sentence_id(sentence_id),
    .sentence_length(sentence_length),
    .computed_sum(computed_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sentence tracker: mirrors the parser state
  logic             trk_active;
  logic [LEN_W-1:0] trk_len;
  logic [7:0]       trk_xor;
  logic             trk_star;
  logic [LEN_W-1:0] trk_last_star;
  logic [15:0]      trk_sum_chars;
  logic [1:0]       trk_sum_count;
  logic             trk_garbage;
  logic [39:0]      trk_id;

  sentence_result_t expected_sentences[$];
  sentence_result_t want;
  logic [7:0]       line_buf[$];

  int failures = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int rcv_busy_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic void clear_tracker();
    trk_active = 1'b0;
    trk_len = '0;
    trk_xor = 8'h00;
    trk_star = 1'b0;
    trk_last_star = '0;
    trk_sum_chars = 16'h0000;
    trk_sum_count = 2'd0;
    trk_garbage = 1'b0;
    trk_id = 40'h0;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic last);
    logic [LEN_W-1:0] idx;
    sentence_result_t r;
    int hi;
    int lo;
    logic has_sum;
    logic sum_good;
    if (!trk_active) begin
      if (b == CH_DOLLAR || b == CH_BANG) begin
        clear_tracker();
        trk_active = 1'b1;
        trk_len = LEN_W'(1);
      end
    end else begin
      idx = trk_len;
      if (trk_len < MAX_LEN) trk_len++;
      if ((b < CH_LOW || b > CH_HIGH) && b != CH_CR && b != CH_LF) trk_garbage = 1'b1;
      if (idx <= ID_LAST) trk_id = {trk_id[31:0], b};
      if (trk_star && trk_sum_count < SUM_CHARS) begin
        trk_sum_chars = {trk_sum_chars[7:0], b};
        trk_sum_count++;
      end
      if (b == CH_STAR) begin
        trk_star = 1'b1;
        trk_last_star = idx;
      end else if (!trk_star) begin
        trk_xor ^= b;
      end
    end
    if (last) begin
      if (trk_active && trk_len >= MIN_LEN) begin
        hi = hex_digit(trk_sum_chars[15:8]);
        lo = hex_digit(trk_sum_chars[7:0]);
        sum_good = trk_sum_count == SUM_CHARS && hi >= 0 && lo >= 0 && (hi * 16 + lo) == trk_xor;
        has_sum = trk_star && (trk_last_star + SUM_TAIL >= trk_len);
        if (trk_garbage) r.status = ST_CANNOT_PARSE;
        else if (has_sum && !sum_good) r.status = ST_BAD_SUM;
        else r.status = ST_OK;
        r.id = trk_garbage ? 40'h0 : trk_id;
        r.len = LEN_OUT_W'(trk_len);
        r.sum = trk_xor;
        expected_sentences.push_back(r);
      end
      clear_tracker();
    end
  endfunction

  function automatic void check_field(input string name, input logic [39:0] exp_val,
                                      input logic [39:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_sentences.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status=%0d id=%h len=%0d sum=%h",
                 $time, status, sentence_id, sentence_length, computed_sum);
        failures++;
      end else begin
        want = expected_sentences.pop_front();
        check_field("status", want.status, status);
        check_field("sentence_id", want.id, sentence_id);
        check_field("sentence_length", want.len, sentence_length);
        check_field("computed_sum", want.sum, computed_sum);
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rcv_busy_pct != 0 && $urandom_range(99) < rcv_busy_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_sentences.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int gap_pct, input int busy_pct);
    send_gap_pct = gap_pct;
    rcv_busy_pct = busy_pct;
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 10) return "0" + n;
    return 8'((lower ? "a" : "A") + n - 10);
  endfunction

  // appends '*' and the sum characters for what is in line_buf so far; SUM_SHORT gives only the first
  task automatic put_checksum(input logic lower, input sum_damage_t damage);
    int i;
    logic started;
    logic [7:0] x;
    started = 1'b0;
    x = 8'h00;
    for (i = 0; i < line_buf.size(); i++) begin
      if (started && line_buf[i] == CH_STAR) break;
      if (started) x ^= line_buf[i];
      if (line_buf[i] == CH_DOLLAR || line_buf[i] == CH_BANG) started = 1'b1;
    end
    if (damage == SUM_WRONG) x ^= 8'($urandom_range(1, 255));
    line_buf.push_back(CH_STAR);
    line_buf.push_back(hex_char(x[7:4], lower));
    if (damage == SUM_NOT_HEX) line_buf.push_back("G" + 8'($urandom_range(19)));
    else if (damage != SUM_SHORT) line_buf.push_back(hex_char(x[3:0], lower));
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = 8'($urandom_range(CH_LOW, CH_HIGH));
    if (c == CH_STAR) c = ",";
    return c;
  endfunction

  function automatic logic [7:0] garbage_char();
    if ($urandom_range(1)) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(8'h7F, 8'hFF));
  endfunction

  task automatic put_crlf();
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endtask

  task automatic test_valid_sentences();
    set_idling(0, 0);
    put_text("$GPGGA,123519,4807.038,N");
    put_checksum(1'b0, SUM_INTACT);
    put_crlf();
    send_line();
    put_text("!AIVDM,1,1,,A,13u?et");
    put_checksum(1'b1, SUM_INTACT);
    send_line();
    // shortest sentence with a result, no checksum field
    put_text("$GPGLL");
    send_line();
    // a later marker is an ordinary byte
    put_text("$GP$!L,a!$");
    put_checksum(1'b0, SUM_INTACT);
    send_line();
    // tag-block prefix holding its own '*'
    put_text("\\s:r3,c:12*1A\\$IIMWV,045,R");
    put_checksum(1'b0, SUM_INTACT);
    put_crlf();
    send_line();
    wait_idle();
  endtask

  task automatic test_bad_checksums();
    set_idling(0, 0);
    put_text("$GPRMC,A,~~");
    put_checksum(1'b0, SUM_WRONG);
    send_line();
    put_text("$GPRMC,A,~~");
    put_checksum(1'b1, SUM_NOT_HEX);
    put_crlf();
    send_line();
    put_text("$GPRMC,A,~~");
    put_checksum(1'b0, SUM_SHORT);
    send_line();
    // star as the very last byte
    put_text("$GPVTG,12*");
    send_line();
    wait_idle();
  endtask

  task automatic test_garbage();
    set_idling(0, 0);
    put_text("$GPZDA,");
    line_buf.push_back(8'hFF);
    put_text("x");
    put_checksum(1'b0, SUM_WRONG);
    send_line();
    put_text("$GPZDA,");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'h7F);
    line_buf.push_back(8'h80);
    line_buf.push_back(8'h1F);
    send_line();
    // CR and LF inside are allowed
    put_text("$GPZDA,");
    put_crlf();
    put_text("ok");
    put_checksum(1'b0, SUM_INTACT);
    send_line();
    wait_idle();
  endtask

  task automatic test_no_result();
    set_idling(0, 0);
    put_text("no marker here");
    send_line();
    put_text("$GPGG");
    send_line();
    put_text("!");
    send_line();
    put_text("xx$");
    send_line();
    wait_idle();
  endtask

  task automatic test_checksum_window();
    set_idling(0, 0);
    // star six bytes before the end: checksum tested
    put_text("$GPAB,*zz123");
    send_line();
    // star seven bytes before the end: not tested
    put_text("$GPAB*zz1234");
    send_line();
    // early star, later star near the end decides the test
    put_text("$GPAB,*1F,abc,def*");
    send_line();
    wait_idle();
  endtask

  // length saturates; a star past the saturation point counts as near the end
  task automatic test_long_sentences();
    int i;
    set_idling(0, 0);
    put_text("$GPLNG,1*00,");
    for (i = 0; i < 1020; i++) line_buf.push_back(field_char());
    put_text("*00,tail,more");
    send_line();
    wait_idle();
  endtask

  // downstream held off long enough that the block backs up into its input
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_request = 300;
    repeat (8) begin
      put_text("$GPTXT,1");
      put_checksum(1'b0, SUM_INTACT);
      send_line();
    end
    wait_idle();
  endtask

  task automatic put_random_sentence();
    int body_len;
    int i;
    int pick;
    if ($urandom_range(3) == 0) begin
      for (i = $urandom_range(1, 8); i > 0; i--) begin
        pick = $urandom_range(255);
        if (pick == CH_DOLLAR || pick == CH_BANG) pick = "#";
        line_buf.push_back(8'(pick));
      end
    end
    line_buf.push_back($urandom_range(1) ? CH_DOLLAR : CH_BANG);
    repeat (5) line_buf.push_back(8'($urandom_range("A", "Z")));
    body_len = $urandom_range(0, ($urandom_range(9) == 0) ? 60 : 15);
    for (i = 0; i < body_len; i++) begin
      pick = $urandom_range(79);
      if (pick == 0) line_buf.push_back(garbage_char());
      else if (pick == 1) line_buf.push_back(CH_STAR);
      else line_buf.push_back(field_char());
    end
    if ($urandom_range(9) < 7) begin
      pick = $urandom_range(9);
      put_checksum(1'($urandom_range(1)),
                   pick < 7 ? SUM_INTACT : pick == 7 ? SUM_WRONG : pick == 8 ? SUM_NOT_HEX
                                                                   : SUM_SHORT);
      if ($urandom_range(9) == 0)
        for (i = $urandom_range(1, 8); i > 0; i--) line_buf.push_back(field_char());
    end
    if ($urandom_range(9) < 6) put_crlf();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int busy_pct, input int n_bytes);
    int goal;
    int pick;
    int i;
    set_idling(gap_pct, busy_pct);
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        put_random_sentence();
      end else if (pick < 87) begin
        // too short to report, or just long enough
        line_buf.push_back($urandom_range(1) ? CH_DOLLAR : CH_BANG);
        for (i = $urandom_range(0, 6); i > 0; i--) line_buf.push_back(field_char());
      end else begin
        for (i = $urandom_range(1, 12); i > 0; i--)
          line_buf.push_back(8'($urandom_range(255)));
      end
      send_line();
    end
    wait_idle();
  endtask

  initial begin
    clear_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_valid_sentences();
    test_bad_checksums();
    test_garbage();
    test_no_result();
    test_checksum_window();
    test_long_sentences();
    test_output_backpressure();
    test_random_traffic(0, 0, 120);
    test_random_traffic(56, 0, 120);
    test_random_traffic(0, 56, 120);
    test_random_traffic(18, 18, 120);
    wait_idle();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nmeachk_pkg.sv
rtl/nmeachk_parser.sv
rtl/nmea0183_sentence_checker.sv
rtl/nmeachk_checker.sv
verif/nmea0183_sentence_checker_test.sv
